// ===== rtl/cpc_pkg.sv =====
package cpc_pkg;

  localparam int FLD_W  = 24;
  localparam int RAD_W  = 16;
  localparam int SUM_W  = 17;   // radius sum and root
  localparam int DEL_W  = 18;   // centre delta while overlapping, signed
  localparam int NRM_W  = 18;   // q16 normal, signed
  localparam int RAD2_W = 34;   // squared distance seen by the root
  localparam int NORM_BITS = 16;
  localparam int ACC_W  = 28;   // pre-saturation width

  typedef logic signed [FLD_W-1:0] fld_t;

  typedef struct packed {
    fld_t             first_pos_x;
    fld_t             first_pos_y;
    logic [RAD_W-1:0] first_radius;
    fld_t             first_vel_x;
    fld_t             first_vel_y;
    fld_t             second_pos_x;
    fld_t             second_pos_y;
    logic [RAD_W-1:0] second_radius;
    fld_t             second_vel_x;
    fld_t             second_vel_y;
  } in_t;

  typedef struct packed {
    fld_t new_first_pos_x;
    fld_t new_first_pos_y;
    fld_t new_first_vel_x;
    fld_t new_first_vel_y;
    fld_t new_second_pos_x;
    fld_t new_second_pos_y;
    fld_t new_second_vel_x;
    fld_t new_second_vel_y;
    logic collided;
    logic coincident;
  } out_t;

  // everything one pair carries down the pipe
  typedef struct packed {
    in_t                      pair;
    logic [SUM_W-1:0]         s;
    logic [SUM_W-1:0]         cdist;
    logic signed [DEL_W-1:0]  dx;
    logic signed [DEL_W-1:0]  dy;
    logic signed [NRM_W-1:0]  nx;
    logic signed [NRM_W-1:0]  ny;
    logic                     hit;
    logic                     coin;
  } item_t;

  function automatic fld_t sat24(input logic signed [ACC_W-1:0] v);
    fld_t r;
    if (v > ACC_W'(signed'(24'sh7FFFFF))) begin
      r = 24'sh7FFFFF;
    end else if (v < ACC_W'(signed'(24'sh800000))) begin
      r = 24'sh800000;
    end else begin
      r = v[FLD_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/cpc_if.sv =====
interface cpc_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/circle_pair_collision_core.sv =====
// equal-mass elastic collision of two circles, one candidate pair per item and one result
// per item, in order. fully pipelined: a new pair is taken every clock while the output
// is not stalled, and every pair passes 3 front stages for deltas, squares and the overlap
// test, 17 stages of the square-root unit at one root bit each, 19 stages of the two-lane
// normal divider at one quotient bit each plus rounding, and 6 resolve stages with the
// output register. a stalled result freezes the whole pipe, so nothing is lost or
// repeated; while the output register is empty or being taken, req.ready stays high.
// coincident centres pass both circles unchanged and raise coincident; outputs saturate
module circle_pair_collision_core (
  input  logic  clk,
  input  logic  rst,
  cpc_if.sink   req,
  cpc_if.source rsp
);

  logic           en;
  logic           f_valid, s_valid, d_valid, r_valid;
  cpc_pkg::item_t f_item, s_item, d_item;
  logic [cpc_pkg::RAD2_W-1:0] f_rad;
  cpc_pkg::out_t  r_data;

  // whole pipe advances unless a finished result is held back
  assign en        = !r_valid || rsp.ready;
  assign req.ready = en;

  // deltas, squared distance, overlap and coincidence
  cpc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (req.valid),
    .in_data   (req.payload),
    .out_valid (f_valid),
    .out_item  (f_item),
    .out_rad   (f_rad)
  );

  // centre distance, floor of the root
  cpc_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_valid),
    .in_item   (f_item),
    .in_rad    (f_rad),
    .out_valid (s_valid),
    .out_item  (s_item)
  );

  // unit normal in q16
  cpc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_valid),
    .in_item   (s_item),
    .out_valid (d_valid),
    .out_item  (d_item)
  );

  // separation, velocity exchange, saturation
  cpc_resolve u_resolve (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (d_valid),
    .in_item   (d_item),
    .out_valid (r_valid),
    .out_data  (r_data)
  );

  assign rsp.valid   = r_valid;
  assign rsp.payload = r_data;

  // a pair is never both coincident and resolved
  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    r_valid |-> !(r_data.collided && r_data.coincident))
    else $error("collided and coincident both set");

  // coincident pairs leave with equal centres
  a_coin_pos: assert property (@(posedge clk) disable iff (rst)
    r_valid && r_data.coincident |->
      (r_data.new_first_pos_x == r_data.new_second_pos_x) &&
      (r_data.new_first_pos_y == r_data.new_second_pos_y))
    else $error("coincident pair moved");

  // reset empties the pipe
  a_rst_empty: assert property (@(posedge clk) rst |=> !r_valid)
    else $error("result valid after reset");

endmodule

// ===== rtl/cpc_front.sv =====
module cpc_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  cpc_pkg::in_t                 in_data,
  output logic                         out_valid,
  output cpc_pkg::item_t               out_item,
  output logic [cpc_pkg::RAD2_W-1:0]   out_rad
);

  logic [2:0] v;
  cpc_pkg::in_t p1, p2;
  logic signed [24:0] dx1, dy1, dx2, dy2;
  logic [cpc_pkg::SUM_W-1:0] s1, s2;
  logic [49:0] sqx, sqy;
  logic [33:0] ss;
  logic coin2;
  logic [50:0] d2;
  cpc_pkg::item_t it3;
  logic [33:0] rad3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[1:0], in_valid};
    end
  end

  // deltas and radius sum
  always_ff @(posedge clk) begin
    if (en) begin
      p1  <= in_data;
      dx1 <= 25'(in_data.second_pos_x) - 25'(in_data.first_pos_x);
      dy1 <= 25'(in_data.second_pos_y) - 25'(in_data.first_pos_y);
      s1  <= {1'b0, in_data.first_radius} + {1'b0, in_data.second_radius};
    end
  end

  // squares
  always_ff @(posedge clk) begin
    if (en) begin
      p2    <= p1;
      dx2   <= dx1;
      dy2   <= dy1;
      s2    <= s1;
      sqx   <= 50'(dx1 * dx1);
      sqy   <= 50'(dy1 * dy1);
      ss    <= 34'(s1 * s1);
      coin2 <= (dx1 == '0) && (dy1 == '0);
    end
  end

  assign d2 = {1'b0, sqx} + {1'b0, sqy};

  // overlap test
  always_ff @(posedge clk) begin
    if (en) begin
      it3.pair  <= p2;
      it3.s     <= s2;
      it3.cdist <= '0;
      it3.dx    <= dx2[cpc_pkg::DEL_W-1:0];
      it3.dy    <= dy2[cpc_pkg::DEL_W-1:0];
      it3.nx    <= '0;
      it3.ny    <= '0;
      it3.coin  <= coin2;
      it3.hit   <= !coin2 && (d2 < {17'b0, ss});
      rad3      <= d2[33:0];
    end
  end

  assign out_valid = v[2];
  assign out_item  = it3;
  assign out_rad   = rad3;

endmodule

// ===== rtl/cpc_sqrt.sv =====
module cpc_sqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  cpc_pkg::item_t             in_item,
  input  logic [cpc_pkg::RAD2_W-1:0] in_rad,
  output logic                       out_valid,
  output cpc_pkg::item_t             out_item
);

  localparam int STEPS = cpc_pkg::SUM_W;
  localparam int AW    = cpc_pkg::RAD2_W + 1;

  logic [STEPS:0]  v;
  logic [AW-1:0]   rem  [STEPS+1];
  logic [AW-1:0]   root [STEPS+1];
  cpc_pkg::item_t  it   [STEPS+1];

  assign v[0]    = in_valid;
  assign rem[0]  = {1'b0, in_rad};
  assign root[0] = '0;
  assign it[0]   = in_item;

  // one result bit per stage, digit by digit
  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam logic [AW-1:0] BIT = AW'(1) << (2 * (STEPS - 1 - k));
    logic [AW-1:0] trial;
    logic          ge;
    assign trial = root[k] + BIT;
    assign ge    = rem[k] >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= ge ? rem[k] - trial : rem[k];
        root[k+1] <= ge ? (root[k] >> 1) + BIT : root[k] >> 1;
        it[k+1]   <= it[k];
      end
    end
  end

  always_comb begin
    out_item       = it[STEPS];
    out_item.cdist = root[STEPS][cpc_pkg::SUM_W-1:0];
  end
  assign out_valid = v[STEPS];

endmodule

// ===== rtl/cpc_div.sv =====
module cpc_div (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  cpc_pkg::item_t in_item,
  output logic           out_valid,
  output cpc_pkg::item_t out_item
);

  // quotient of |d| * 2^17 / dist, one bit per stage, x and y side by side
  localparam int STEPS = cpc_pkg::NORM_BITS + 2;
  localparam int AW    = cpc_pkg::DEL_W + cpc_pkg::NORM_BITS + 1;
  localparam int QW    = STEPS;

  logic [STEPS:0]  v;
  logic [AW-1:0]   rx [STEPS+1];
  logic [AW-1:0]   ry [STEPS+1];
  logic [QW-1:0]   qx [STEPS+1];
  logic [QW-1:0]   qy [STEPS+1];
  cpc_pkg::item_t  it [STEPS+1];
  logic [cpc_pkg::DEL_W-1:0] ax, ay;
  logic            vo;
  cpc_pkg::item_t  ito;
  cpc_pkg::item_t  ito_next;
  logic signed [QW:0] sqx, sqy;

  assign ax = in_item.dx[cpc_pkg::DEL_W-1] ? cpc_pkg::DEL_W'(-in_item.dx)
                                            : cpc_pkg::DEL_W'(in_item.dx);
  assign ay = in_item.dy[cpc_pkg::DEL_W-1] ? cpc_pkg::DEL_W'(-in_item.dy)
                                            : cpc_pkg::DEL_W'(in_item.dy);

  assign v[0]  = in_valid;
  assign rx[0] = {ax, (cpc_pkg::NORM_BITS + 1)'(0)};
  assign ry[0] = {ay, (cpc_pkg::NORM_BITS + 1)'(0)};
  assign qx[0] = '0;
  assign qy[0] = '0;
  assign it[0] = in_item;

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic [AW-1:0] sub;
    logic gx, gy;
    assign sub = AW'(it[k].cdist) << (STEPS - 1 - k);
    assign gx  = rx[k] >= sub;
    assign gy  = ry[k] >= sub;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rx[k+1] <= gx ? rx[k] - sub : rx[k];
        ry[k+1] <= gy ? ry[k] - sub : ry[k];
        qx[k+1] <= {qx[k][QW-2:0], gx};
        qy[k+1] <= {qy[k][QW-2:0], gy};
        it[k+1] <= it[k];
      end
    end
  end

  // restore sign, then round half up to q16
  assign sqx = it[STEPS].dx[cpc_pkg::DEL_W-1] ? -signed'({1'b0, qx[STEPS]})
                                               : signed'({1'b0, qx[STEPS]});
  assign sqy = it[STEPS].dy[cpc_pkg::DEL_W-1] ? -signed'({1'b0, qy[STEPS]})
                                               : signed'({1'b0, qy[STEPS]});

  always_comb begin
    ito_next    = it[STEPS];
    ito_next.nx = cpc_pkg::NRM_W'((sqx + (QW+1)'(1)) >>> 1);
    ito_next.ny = cpc_pkg::NRM_W'((sqy + (QW+1)'(1)) >>> 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vo <= 1'b0;
    end else if (en) begin
      vo <= v[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ito <= ito_next;
    end
  end

  assign out_valid = vo;
  assign out_item  = ito;

endmodule

// ===== rtl/cpc_resolve.sv =====
module cpc_resolve (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  cpc_pkg::item_t in_item,
  output logic           out_valid,
  output cpc_pkg::out_t  out_data
);

  localparam int AW = cpc_pkg::ACC_W;

  logic [5:0] v;
  cpc_pkg::item_t i1, i2, i3, i4, i5;
  logic signed [17:0] ov;
  logic signed [35:0] pex, pey;
  logic signed [41:0] m1x, m1y, m2x, m2y;
  logic signed [18:0] ex2, ey2, ex3, ey3, ex4, ey4, ex5, ey5;
  logic signed [42:0] v1n, v2n;
  logic signed [43:0] dv;
  logic signed [39:0] phx, phy;
  logic signed [40:0] plx, ply;
  logic signed [63:0] sx, sy;
  logic signed [AW-1:0] fx, fy;
  cpc_pkg::out_t o6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[4:0], in_valid};
    end
  end

  assign ov = signed'({1'b0, in_item.s}) - signed'({1'b0, in_item.cdist});

  // products with the normal
  always_ff @(posedge clk) begin
    if (en) begin
      i1  <= in_item;
      pex <= 36'(in_item.nx * ov);
      pey <= 36'(in_item.ny * ov);
      m1x <= 42'(in_item.pair.first_vel_x * in_item.nx);
      m1y <= 42'(in_item.pair.first_vel_y * in_item.ny);
      m2x <= 42'(in_item.pair.second_vel_x * in_item.nx);
      m2y <= 42'(in_item.pair.second_vel_y * in_item.ny);
    end
  end

  // half overlap, normal speeds
  always_ff @(posedge clk) begin
    if (en) begin
      i2  <= i1;
      ex2 <= 19'((pex + 36'sd65536) >>> 17);
      ey2 <= 19'((pey + 36'sd65536) >>> 17);
      v1n <= 43'(m1x) + 43'(m1y);
      v2n <= 43'(m2x) + 43'(m2y);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      i3  <= i2;
      ex3 <= ex2;
      ey3 <= ey2;
      dv  <= 44'(v2n) - 44'(v1n);
    end
  end

  // dv times normal, split into high and low partial products
  always_ff @(posedge clk) begin
    if (en) begin
      i4  <= i3;
      ex4 <= ex3;
      ey4 <= ey3;
      phx <= 40'(signed'(dv[43:22]) * i3.nx);
      phy <= 40'(signed'(dv[43:22]) * i3.ny);
      plx <= 41'(signed'({1'b0, dv[21:0]}) * i3.nx);
      ply <= 41'(signed'({1'b0, dv[21:0]}) * i3.ny);
    end
  end

  assign sx = (64'(phx) <<< 22) + 64'(plx) + 64'sh80000000;
  assign sy = (64'(phy) <<< 22) + 64'(ply) + 64'sh80000000;

  always_ff @(posedge clk) begin
    if (en) begin
      i5  <= i4;
      ex5 <= ex4;
      ey5 <= ey4;
      fx  <= AW'(sx >>> 32);
      fy  <= AW'(sy >>> 32);
    end
  end

  // apply and saturate
  always_ff @(posedge clk) begin
    if (en) begin
      o6.collided   <= i5.hit;
      o6.coincident <= i5.coin;
      if (i5.hit) begin
        o6.new_first_pos_x  <= cpc_pkg::sat24(AW'(i5.pair.first_pos_x) - AW'(ex5));
        o6.new_first_pos_y  <= cpc_pkg::sat24(AW'(i5.pair.first_pos_y) - AW'(ey5));
        o6.new_second_pos_x <= cpc_pkg::sat24(AW'(i5.pair.second_pos_x) + AW'(ex5));
        o6.new_second_pos_y <= cpc_pkg::sat24(AW'(i5.pair.second_pos_y) + AW'(ey5));
        o6.new_first_vel_x  <= cpc_pkg::sat24(AW'(i5.pair.first_vel_x) + fx);
        o6.new_first_vel_y  <= cpc_pkg::sat24(AW'(i5.pair.first_vel_y) + fy);
        o6.new_second_vel_x <= cpc_pkg::sat24(AW'(i5.pair.second_vel_x) - fx);
        o6.new_second_vel_y <= cpc_pkg::sat24(AW'(i5.pair.second_vel_y) - fy);
      end else begin
        o6.new_first_pos_x  <= i5.pair.first_pos_x;
        o6.new_first_pos_y  <= i5.pair.first_pos_y;
        o6.new_second_pos_x <= i5.pair.second_pos_x;
        o6.new_second_pos_y <= i5.pair.second_pos_y;
        o6.new_first_vel_x  <= i5.pair.first_vel_x;
        o6.new_first_vel_y  <= i5.pair.first_vel_y;
        o6.new_second_vel_x <= i5.pair.second_vel_x;
        o6.new_second_vel_y <= i5.pair.second_vel_y;
      end
    end
  end

  assign out_valid = v[5];
  assign out_data  = o6;

endmodule
